// ----- hdl/pcsenc_pkg.sv -----
package pcsenc_pkg;

   localparam int BYTE_W     = 8;
   localparam int SYNC_W     = 2;
   localparam int BLOCK_W    = 64;
   localparam int SEED_W     = 58;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SEED_W;
   localparam int IDLE_CNT_W = 6;

   localparam logic [SYNC_W-1:0] SYNC_CTRL = 2'd1;
   localparam logic [SYNC_W-1:0] SYNC_DATA = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_GAP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED     = 2'd1;

   localparam logic [7:0] MIN_GAP   = 8'd12;
   localparam logic [7:0] BLOCK_LEN = 8'd8;

   localparam logic [SEED_W-1:0] SEED_RESET = {SEED_W{1'b1}};

   localparam logic [7:0] TYPE_IDLE   = 8'h1e;
   localparam logic [7:0] TYPE_START3 = 8'h33;
   localparam logic [7:0] TYPE_START7 = 8'h78;

   localparam logic [7:0] TERM_TYPE [8] = '{8'h87, 8'h99, 8'haa, 8'hb4,
                                            8'hcc, 8'hd2, 8'he1, 8'hff};

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_START3,
      PH_START7,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      SQ_READY,
      SQ_PICK,
      SQ_SCRAM,
      SQ_HOLD
   } seq_state_type;

   typedef struct packed {
      logic              gap_load;
      logic [7:0]        gap;
      logic              seed_load;
      logic [SEED_W-1:0] seed;
   } cfg_type;

   typedef struct packed {
      logic [IDLE_CNT_W-1:0] idle_cnt;
      logic                  mid_go;
      logic [SYNC_W-1:0]     mid_hdr;
      logic [BLOCK_W-1:0]    mid_pay;
      logic                  term_go;
      logic [BLOCK_W-1:0]    term_pay;
   } plan_type;

   typedef struct packed {
      logic               start;
      logic [BLOCK_W-1:0] payload;
   } scr_req_type;

   typedef struct packed {
      logic               done;
      logic [BLOCK_W-1:0] result;
   } scr_rsp_type;

endpackage

// ----- hdl/pcsenc_intf.sv -----
interface pcsenc_req_if import pcsenc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface pcsenc_rsp_if import pcsenc_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SYNC_W-1:0]  blk_sync;
   logic [BLOCK_W-1:0] block_payload;
   logic               last_of_run;

   modport source (output valid, output blk_sync, output block_payload,
                   output last_of_run, input ready);
   modport sink (input valid, input blk_sync, input block_payload,
                 input last_of_run, output ready);
endinterface

interface pcsenc_csr_if import pcsenc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- hdl/pcsenc_scrambler.sv -----
module pcsenc_scrambler import pcsenc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  scr_req_type req,
   output scr_rsp_type rsp
);

   logic [SEED_W-1:0]  s_ff;
   logic [SEED_W-1:0]  s_in;
   logic [BLOCK_W-1:0] data_ff;
   logic [BLOCK_W-1:0] data_in;
   logic [2:0]         step_ff;
   logic               busy_ff;
   logic [7:0]         ob;
   logic [SEED_W-1:0]  s_w;

   // scramble one byte, LSB first
   always_comb begin
      s_w = s_ff;
      ob  = '0;
      for (int i = 0; i < 8; i++) begin
         ob[i] = data_ff[i] ^ s_w[38] ^ s_w[57];
         s_w   = {s_w[SEED_W-2:0], ob[i]};
      end
      s_in    = s_w;
      data_in = {ob, data_ff[BLOCK_W-1:8]};
   end

   assign rsp.done   = busy_ff && (step_ff == 3'd7);
   assign rsp.result = data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff    <= SEED_RESET;
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (cfg.seed_load) begin
         s_ff    <= cfg.seed;
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         s_ff    <= s_in;
         step_ff <= step_ff + 3'd1;
         busy_ff <= (step_ff != 3'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         data_ff <= req.payload;
      end else if (busy_ff) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- hdl/pcsenc_framer.sv -----
module pcsenc_framer import pcsenc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              accept,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              frame_end,
   output plan_type          plan
);

   logic [7:0]         gap_ff;
   logic [7:0]         pending_ff;
   logic [7:0]         pending_in;
   phase_type          phase_ff;
   phase_type          phase_in;
   logic [BLOCK_W-1:0] word_ff;
   logic [BLOCK_W-1:0] word_in;
   logic [2:0]         cnt_ff;
   logic [2:0]         cnt_in;
   logic               phase0;
   logic [2:0]         rem;
   phase_type          ph;
   logic [BLOCK_W-1:0] w0;
   logic [BLOCK_W-1:0] w1;
   logic [2:0]         c0;
   logic [3:0]         c1;
   logic [2:0]         left;

   always_comb begin
      phase0 = (phase_ff == PH_WAIT);
      rem    = pending_ff[2:0];
      plan   = '0;
      if (phase0) begin
         plan.idle_cnt = {1'b0, pending_ff[7:3]} + {5'd0, (rem >= 3'd5)};
         ph = ((rem != 3'd0) && (rem <= 3'd4)) ? PH_START3 : PH_START7;
         w0 = '0;
         c0 = '0;
         pending_in = '0;
      end else begin
         ph = phase_ff;
         w0 = word_ff;
         c0 = cnt_ff;
         pending_in = pending_ff;
      end
      w1 = w0 | ({{(BLOCK_W-BYTE_W){1'b0}}, data_byte} << {c0, 3'b000});
      c1 = {1'b0, c0} + 4'd1;

      phase_in      = ph;
      word_in       = w1;
      cnt_in        = c1[2:0];
      plan.mid_hdr  = SYNC_CTRL;
      plan.mid_pay  = w1;

      case (ph)
         PH_START3: begin
            if (c1 >= 4'd3) begin
               plan.mid_go  = 1'b1;
               plan.mid_pay = {w1[23:0], 32'd0, TYPE_START3};
               phase_in     = PH_DATA;
               word_in      = '0;
               cnt_in       = '0;
               plan.term_go = frame_end;
            end
         end
         PH_START7: begin
            if (c1 >= 4'd7) begin
               plan.mid_go  = 1'b1;
               plan.mid_pay = {w1[55:0], TYPE_START7};
               phase_in     = PH_DATA;
               word_in      = '0;
               cnt_in       = '0;
               plan.term_go = frame_end;
            end
         end
         default: begin
            if (c1[3]) begin
               plan.mid_go  = 1'b1;
               plan.mid_hdr = SYNC_DATA;
               word_in      = '0;
               cnt_in       = '0;
            end
            plan.term_go = frame_end;
         end
      endcase

      left          = cnt_in;
      plan.term_pay = {word_in[55:0], TERM_TYPE[left]};
      if (plan.term_go) begin
         phase_in   = PH_WAIT;
         word_in    = '0;
         cnt_in     = '0;
         pending_in = gap_ff - BLOCK_LEN + {5'd0, left};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff     <= MIN_GAP;
         pending_ff <= MIN_GAP;
         phase_ff   <= PH_WAIT;
         cnt_ff     <= '0;
      end else if (cfg.gap_load) begin
         gap_ff     <= cfg.gap;
         pending_ff <= cfg.gap;
      end else if (accept) begin
         pending_ff <= pending_in;
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

endmodule

// ----- hdl/pcsenc_seq.sv -----
module pcsenc_seq import pcsenc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  plan_type           plan,
   output scr_req_type        scr_req,
   input  scr_rsp_type        scr_rsp,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [SYNC_W-1:0]  out_hdr,
   output logic [BLOCK_W-1:0] out_payload,
   output logic               out_last
);

   seq_state_type         state_ff;
   seq_state_type         state_in;
   logic [IDLE_CNT_W-1:0] idle_left_ff;
   logic                  mid_go_ff;
   logic [SYNC_W-1:0]     mid_hdr_ff;
   logic [BLOCK_W-1:0]    mid_pay_ff;
   logic                  term_go_ff;
   logic [BLOCK_W-1:0]    term_pay_ff;
   logic [SYNC_W-1:0]     hdr_ff;
   logic                  last_ff;
   logic                  rsp_valid_ff;
   logic [SYNC_W-1:0]     rsp_hdr_ff;
   logic [BLOCK_W-1:0]    rsp_pay_ff;
   logic                  rsp_last_ff;
   logic                  have_idle;
   logic                  any_block;
   logic [BLOCK_W-1:0]    sel_pay;
   logic [SYNC_W-1:0]     sel_hdr;
   logic                  sel_last;
   logic                  accept;
   logic                  out_take;

   assign have_idle = (idle_left_ff != '0);
   assign any_block = have_idle || mid_go_ff || term_go_ff;
   assign accept    = item_valid && item_ready;
   assign out_take  = rsp_valid_ff && out_ready;

   always_comb begin
      if (have_idle) begin
         sel_pay  = {{(BLOCK_W-8){1'b0}}, TYPE_IDLE};
         sel_hdr  = SYNC_CTRL;
         sel_last = (idle_left_ff == 6'd1) && !mid_go_ff && !term_go_ff;
      end else if (mid_go_ff) begin
         sel_pay  = mid_pay_ff;
         sel_hdr  = mid_hdr_ff;
         sel_last = !term_go_ff;
      end else begin
         sel_pay  = term_pay_ff;
         sel_hdr  = SYNC_CTRL;
         sel_last = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SQ_READY: if (item_valid) state_in = SQ_PICK;
         SQ_PICK:  state_in = any_block ? SQ_SCRAM : SQ_READY;
         SQ_SCRAM: if (scr_rsp.done) state_in = SQ_HOLD;
         SQ_HOLD:  if (out_take) state_in = SQ_PICK;
         default:  state_in = SQ_READY;
      endcase
   end

   always_comb begin
      item_ready      = (state_ff == SQ_READY);
      scr_req.start   = (state_ff == SQ_PICK) && any_block;
      scr_req.payload = sel_pay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_READY;
         idle_left_ff <= '0;
         mid_go_ff    <= 1'b0;
         term_go_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            idle_left_ff <= plan.idle_cnt;
            mid_go_ff    <= plan.mid_go;
            term_go_ff   <= plan.term_go;
         end else if (scr_req.start) begin
            if (have_idle) begin
               idle_left_ff <= idle_left_ff - 6'd1;
            end else if (mid_go_ff) begin
               mid_go_ff <= 1'b0;
            end else begin
               term_go_ff <= 1'b0;
            end
         end
         if (scr_rsp.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_hdr_ff  <= plan.mid_hdr;
         mid_pay_ff  <= plan.mid_pay;
         term_pay_ff <= plan.term_pay;
      end
      if (scr_req.start) begin
         hdr_ff  <= sel_hdr;
         last_ff <= sel_last;
      end
      if (scr_rsp.done) begin
         rsp_hdr_ff  <= hdr_ff;
         rsp_pay_ff  <= scr_rsp.result;
         rsp_last_ff <= last_ff;
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign out_hdr     = rsp_hdr_ff;
   assign out_payload = rsp_pay_ff;
   assign out_last    = rsp_last_ff;

endmodule

// ----- hdl/pcs_64b66b_encoder_scrambler.sv -----
// Each 66-bit block is picked, scrambled a byte at a time by the byte-wide scrambler,
// then held until the output takes it; a new input byte is not accepted until every
// block that the last accepted byte caused has been handed off.
// Reset (synchronous, active high): idle gap 12, pending idles 12, scrambler all ones,
// waiting for a frame start, no block held.
module pcs_64b66b_encoder_scrambler import pcsenc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pcsenc_req_if.sink   req_if,
   pcsenc_rsp_if.source rsp_if,
   pcsenc_csr_if.sink   csr_if
);

   cfg_type     cfg;
   plan_type    plan;
   scr_req_type scr_req;
   scr_rsp_type scr_rsp;
   logic        csr_accept;
   logic        req_accept;
   logic [7:0]  gap_raw;

   assign csr_if.ready = 1'b1;
   assign csr_accept   = csr_if.valid && csr_if.ready;
   assign gap_raw      = csr_if.wdata[7:0];

   always_comb begin
      cfg.gap_load  = csr_accept && (csr_if.index == CSR_IDLE_GAP);
      cfg.gap       = (gap_raw < MIN_GAP) ? MIN_GAP : gap_raw;
      cfg.seed_load = csr_accept && (csr_if.index == CSR_SEED);
      cfg.seed      = csr_if.wdata[SEED_W-1:0];
   end

   assign req_accept = req_if.valid && req_if.ready;

   pcsenc_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (req_accept),
      .data_byte (req_if.data_byte),
      .frame_end (req_if.frame_end),
      .plan      (plan)
   );

   pcsenc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_if.valid),
      .item_ready  (req_if.ready),
      .plan        (plan),
      .scr_req     (scr_req),
      .scr_rsp     (scr_rsp),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_hdr     (rsp_if.blk_sync),
      .out_payload (rsp_if.block_payload),
      .out_last    (rsp_if.last_of_run)
   );

   pcsenc_scrambler u_scrambler (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (scr_req),
      .rsp   (scr_rsp)
   );

endmodule
